FILE: rtl/core/bitmap_frame_allocator_core_defines.svh
// Assertion helpers for the frame allocator core.
// Each one is clocked on clk_i and switched off while rst_ni is low.
`ifndef BITMAP_FRAME_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication
`define BFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/bfa_pkg.sv
package bfa_pkg;

  // Pool geometry
  localparam int MAX_FRAMES = 512;
  localparam int CELL_BITS  = 32;
  localparam int NUM_CELLS  = MAX_FRAMES / CELL_BITS;
  localparam int IDX_W      = $clog2(MAX_FRAMES);
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int CB_W       = $clog2(CELL_BITS);

  // Field widths
  localparam int FRAME_W    = 20;
  localparam int POOL_W     = 10;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_FRAME  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_FRAMES = 1'd1;
  localparam logic [FRAME_W-1:0]   BASE_RESET      = 20'd512;
  localparam logic [POOL_W-1:0]    POOL_RESET      = 10'd512;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MARK    = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FRAME_W-1:0] frame_no;
    logic [POOL_W-1:0]  run_length;
  } bfa_in_t;

  typedef struct packed {
    logic [FRAME_W-1:0]  result_frame;
    logic [STATUS_W-1:0] status;
  } bfa_out_t;

  // Operation carried by the token along the cell chain
  typedef enum logic [1:0] {
    OP_NONE,
    OP_ALLOC,
    OP_RELEASE,
    OP_MARK
  } op_e;

  // Token handed from cell to cell
  typedef struct packed {
    logic                valid;
    op_e                 op;
    logic                found;
    logic [IDX_W-1:0]    idx;     // release target, or allocated index
    logic [CNT_W-1:0]    lo;      // mark run start
    logic [CNT_W-1:0]    hi;      // mark run end (exclusive)
    logic [CNT_W-1:0]    n;       // effective pool size
    logic [STATUS_W-1:0] status;
  } tok_t;

endpackage

FILE: rtl/core/bitmap_frame_allocator_core.sv
// First-fit physical frame allocator over a pool of up to MAX_FRAMES frames
// starting at base_frame. Allocate, release and mark-inaccessible requests
// each give one result beat. The allocated and inaccessible bitmaps live in a
// row of MAX_FRAMES/32 cells of 32 frames each; a request travels down the row
// one cell per cycle. From input beat to result valid it passes the launch
// register, each cell register, the pending register and the output register,
// and no new request is taken until its result enters the output register.
// Range checks are done on entry, before the request reaches the first cell.
`include "bitmap_frame_allocator_core_defines.svh"

module bitmap_frame_allocator_core import bfa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // request channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  bfa_in_t               in_data_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output bfa_out_t              out_data_o
);

  logic [FRAME_W-1:0] base_q;
  logic [POOL_W-1:0]  pool_q;
  logic               busy_q;
  tok_t               launch_q, launch_d;
  logic               pend_valid_q;
  bfa_out_t           pend_q, pend_d;
  logic               out_valid_q;
  bfa_out_t           out_q;

  tok_t               tok [NUM_CELLS+1];
  logic [NUM_CELLS:0] chain_vld;

  logic               in_acc, pend_move;
  logic [CNT_W-1:0]   n_eff;
  logic [FRAME_W-1:0] offset;
  logic [FRAME_W:0]   run_end;
  logic               ge_base, rel_ok, mark_ok;

  assign in_acc     = in_valid_i && in_ready_o;
  assign in_ready_o = !busy_q;
  assign pend_move  = pend_valid_q && (!out_valid_q || out_ready_i);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RESET;
      pool_q <= POOL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BASE_FRAME:  base_q <= cfg_wdata_i[FRAME_W-1:0];
        CFG_POOL_FRAMES: pool_q <= cfg_wdata_i[POOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Entry checks and token build
  always_comb begin
    logic [31:0] pool_ext;
    pool_ext = 32'(pool_q);
    n_eff    = (pool_ext > 32'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES) : CNT_W'(pool_ext);
    ge_base  = in_data_i.frame_no >= base_q;
    offset   = in_data_i.frame_no - base_q;
    run_end  = {1'b0, offset} + (FRAME_W+1)'(in_data_i.run_length);
    rel_ok   = ge_base && (offset < FRAME_W'(n_eff));
    mark_ok  = ge_base && (run_end <= (FRAME_W+1)'(n_eff));

    launch_d        = '0;
    launch_d.valid  = in_acc;
    launch_d.n      = n_eff;
    launch_d.op     = OP_NONE;
    launch_d.status = ST_OK;
    unique case (in_data_i.kind)
      KIND_ALLOC: begin
        launch_d.op     = OP_ALLOC;
        launch_d.status = ST_NO_FREE;
      end
      KIND_RELEASE: begin
        if (rel_ok) begin
          launch_d.op  = OP_RELEASE;
          launch_d.idx = offset[IDX_W-1:0];
        end else begin
          launch_d.status = ST_RANGE;
        end
      end
      KIND_MARK: begin
        if (mark_ok) begin
          launch_d.op = OP_MARK;
          launch_d.lo = offset[CNT_W-1:0];
          launch_d.hi = run_end[CNT_W-1:0];
        end else begin
          launch_d.status = ST_RANGE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_q <= '0;
    end else begin
      launch_q <= launch_d;
    end
  end

  // Cell chain
  assign tok[0]       = launch_q;
  assign chain_vld[0] = tok[0].valid;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    bfa_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cell_base_i (IDX_W'(k * CELL_BITS)),
      .tok_i       (tok[k]),
      .tok_o       (tok[k+1])
    );
    assign chain_vld[k+1] = tok[k+1].valid;
  end

  // Result formation at the end of the chain
  always_comb begin
    pend_d = '0;
    if (tok[NUM_CELLS].op == OP_ALLOC) begin
      if (tok[NUM_CELLS].found) begin
        pend_d.result_frame = base_q + FRAME_W'(tok[NUM_CELLS].idx);
        pend_d.status       = ST_OK;
      end else begin
        pend_d.status = ST_NO_FREE;
      end
    end else begin
      pend_d.status = tok[NUM_CELLS].status;
    end
  end

  // Pending result, output register and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        busy_q <= 1'b1;
      end else if (pend_move) begin
        busy_q <= 1'b0;
      end
      if (tok[NUM_CELLS].valid) begin
        pend_valid_q <= 1'b1;
      end else if (pend_move) begin
        pend_valid_q <= 1'b0;
      end
      if (pend_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok[NUM_CELLS].valid) begin
      pend_q <= pend_d;
    end
    if (pend_move) begin
      out_q <= pend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  `BFA_ASSERT_NOW(a_one_token, 1'b1, $countones(chain_vld) <= 1, "more than one token in chain")
  `BFA_ASSERT_NOW(a_chain_busy, |chain_vld, busy_q, "token in chain while idle")
  `BFA_ASSERT_NOW(a_pend_busy, pend_valid_q, busy_q && !(|chain_vld), "pending result not alone")
  `BFA_ASSERT_NEXT(a_launch, in_acc, tok[0].valid && !pend_valid_q, "accepted beat not launched")

endmodule

FILE: rtl/core/bfa_cell.sv
module bfa_cell import bfa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] cell_base_i,
  input  tok_t             tok_i,
  output tok_t             tok_o
);

  logic [CELL_BITS-1:0] alloc_q, alloc_d;
  logic [CELL_BITS-1:0] blk_q, blk_d;
  tok_t                 tok_q, tok_d;

  logic [CELL_BITS-1:0] in_pool, in_run, free, first, rel_sel;
  logic [CB_W-1:0]      pos;
  logic                 rel_hit;

  // Per-bit masks, lowest free bit and release target
  always_comb begin
    logic [CNT_W-1:0] g;
    pos = '0;
    for (int b = 0; b < CELL_BITS; b++) begin
      g          = CNT_W'(cell_base_i | IDX_W'(b));
      in_pool[b] = g < tok_i.n;
      in_run[b]  = (g >= tok_i.lo) && (g < tok_i.hi);
    end
    free  = ~alloc_q & ~blk_q & in_pool;
    first = free & (~free + CELL_BITS'(1));
    for (int b = 0; b < CELL_BITS; b++) begin
      if (first[b]) begin
        pos = pos | CB_W'(b);
      end
    end
    rel_hit = (tok_i.idx >> CB_W) == (cell_base_i >> CB_W);
    rel_sel = rel_hit ? (CELL_BITS'(1) << tok_i.idx[CB_W-1:0]) : '0;
  end

  // Apply the passing token to this slice of the bitmaps
  always_comb begin
    alloc_d = alloc_q;
    blk_d   = blk_q;
    tok_d   = tok_i;
    if (tok_i.valid) begin
      unique case (tok_i.op)
        OP_ALLOC: begin
          if (!tok_i.found && (|free)) begin
            alloc_d     = alloc_q | first;
            tok_d.found = 1'b1;
            tok_d.idx   = cell_base_i | IDX_W'(pos);
          end
        end
        OP_RELEASE: alloc_d = alloc_q & ~rel_sel;
        OP_MARK:    blk_d   = blk_q | in_run;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_q <= '0;
      blk_q   <= '0;
      tok_q   <= '0;
    end else begin
      alloc_q <= alloc_d;
      blk_q   <= blk_d;
      tok_q   <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule
